>>> rtl/core/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion pipeline.
package rmq_pkg;

  localparam int FRAC_BITS = 30;
  localparam int MAT_W     = 32;
  localparam int THR_W     = 31;
  localparam int RAD_W     = 33;
  localparam int NUM_W     = 33;
  localparam int ROOT_W    = 32;
  localparam int SQ_STEPS  = ROOT_W;
  localparam int DIV_STEPS = 32;
  // front (2) + root (SQ_STEPS) + divide prep and steps + output register
  localparam int NSTG      = 2 + SQ_STEPS + DIV_STEPS + 2;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(11);
  localparam logic             THR_IDX   = 1'b0;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  typedef struct packed {
    logic signed [MAT_W-1:0] m00;
    logic signed [MAT_W-1:0] m01;
    logic signed [MAT_W-1:0] m02;
    logic signed [MAT_W-1:0] m10;
    logic signed [MAT_W-1:0] m11;
    logic signed [MAT_W-1:0] m12;
    logic signed [MAT_W-1:0] m20;
    logic signed [MAT_W-1:0] m21;
    logic signed [MAT_W-1:0] m22;
  } matrix_t;

  typedef struct packed {
    logic signed [MAT_W-1:0] q_w;
    logic signed [MAT_W-1:0] q_x;
    logic signed [MAT_W-1:0] q_y;
    logic signed [MAT_W-1:0] q_z;
    logic [1:0]              branch_taken;
    logic                    invalid;
  } quat_t;

  // numerators of the three divided components, in w,x,y,z order skipping the big one
  typedef struct packed {
    branch_t                 br;
    logic signed [NUM_W-1:0] na;
    logic signed [NUM_W-1:0] nb;
    logic signed [NUM_W-1:0] nc;
  } side_t;

  typedef struct packed {
    branch_t           br;
    logic [ROOT_W-2:0] half;
    logic              inv;
  } tail_t;

endpackage

>>> rtl/core/rmq_front.sv
// Input register, branch choice, radicand and numerators.
module rmq_front import rmq_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  matrix_t          mat,
  input  logic [THR_W-1:0] thr,
  output logic [RAD_W-1:0] rad,
  output side_t            side
);

  matrix_t m;
  logic signed [RAD_W+1:0] one_s, t, r;
  logic [RAD_W-1:0] rad_next;
  side_t side_next;
  logic signed [NUM_W-1:0] d21_12, d02_20, d10_01, s10_01, s02_20, s21_12;

  always_ff @(posedge clk) begin
    if (en) begin
      m <= mat;
    end
  end

  always_comb begin
    one_s  = (RAD_W+2)'(1) <<< FRAC_BITS;
    t      = one_s + (RAD_W+2)'(m.m00) + (RAD_W+2)'(m.m11) + (RAD_W+2)'(m.m22);
    d21_12 = NUM_W'(m.m21) - NUM_W'(m.m12);
    d02_20 = NUM_W'(m.m02) - NUM_W'(m.m20);
    d10_01 = NUM_W'(m.m10) - NUM_W'(m.m01);
    s10_01 = NUM_W'(m.m10) + NUM_W'(m.m01);
    s02_20 = NUM_W'(m.m02) + NUM_W'(m.m20);
    s21_12 = NUM_W'(m.m21) + NUM_W'(m.m12);
    if (t > $signed({4'b0, thr})) begin
      side_next.br = BR_TRACE;
      r = t;
      side_next.na = d21_12;
      side_next.nb = d02_20;
      side_next.nc = d10_01;
    end else if (m.m00 > m.m11 && m.m00 > m.m22) begin
      side_next.br = BR_X;
      r = one_s + (RAD_W+2)'(m.m00) - (RAD_W+2)'(m.m11) - (RAD_W+2)'(m.m22);
      side_next.na = d21_12;
      side_next.nb = s10_01;
      side_next.nc = s02_20;
    end else if (m.m11 > m.m22) begin
      side_next.br = BR_Y;
      r = one_s - (RAD_W+2)'(m.m00) + (RAD_W+2)'(m.m11) - (RAD_W+2)'(m.m22);
      side_next.na = d02_20;
      side_next.nb = s10_01;
      side_next.nc = s21_12;
    end else begin
      side_next.br = BR_Z;
      r = one_s - (RAD_W+2)'(m.m00) - (RAD_W+2)'(m.m11) + (RAD_W+2)'(m.m22);
      side_next.na = d10_01;
      side_next.nb = s02_20;
      side_next.nc = s21_12;
    end
    rad_next = r[RAD_W+1] ? '0 : r[RAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad  <= rad_next;
      side <= side_next;
    end
  end

endmodule

>>> rtl/core/rmq_sqrt.sv
// Pipelined integer square root of rad * 2^FRAC_BITS, two radicand bits per stage.
module rmq_sqrt import rmq_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad_in,
  input  side_t             side_in,
  output logic [ROOT_W-1:0] root,
  output side_t             side
);

  logic [RAD_W-1:0]  rad_q  [SQ_STEPS];
  logic [ROOT_W-1:0] root_q [SQ_STEPS];
  logic [ROOT_W+1:0] rem_q  [SQ_STEPS];
  side_t             side_q [SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
    localparam int B = 2 * (SQ_STEPS - 1 - j);
    logic [RAD_W-1:0]      rad_i;
    logic [ROOT_W-1:0]     root_i;
    logic [ROOT_W+1:0]     rem_i;
    side_t                 side_i;
    logic [2*SQ_STEPS-1:0] xw;
    logic [ROOT_W+3:0]     rem2, trial, diff;
    logic                  ge;

    if (j == 0) begin : g_first
      assign rad_i  = rad_in;
      assign root_i = '0;
      assign rem_i  = '0;
      assign side_i = side_in;
    end else begin : g_next
      assign rad_i  = rad_q[j-1];
      assign root_i = root_q[j-1];
      assign rem_i  = rem_q[j-1];
      assign side_i = side_q[j-1];
    end

    always_comb begin
      xw    = (2*SQ_STEPS)'(rad_i) << FRAC_BITS;
      rem2  = {rem_i, xw[B+1:B]};
      trial = {2'b00, root_i, 2'b01};
      ge    = rem2 >= trial;
      diff  = rem2 - trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[j]  <= rad_i;
        side_q[j] <= side_i;
        root_q[j] <= {root_i[ROOT_W-2:0], ge};
        rem_q[j]  <= ge ? diff[ROOT_W+1:0] : rem2[ROOT_W+1:0];
      end
    end
  end

  assign root = root_q[SQ_STEPS-1];
  assign side = side_q[SQ_STEPS-1];

endmodule

>>> rtl/core/rmq_div.sv
// Pipelined |n| * 2^(FRAC_BITS-1) / h, one quotient bit per stage, with overflow flag.
module rmq_div import rmq_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic [ROOT_W-1:0]       h,
  output logic [ROOT_W-1:0]       quo,
  output logic                    neg,
  output logic                    ovf
);

  // bits of |n| that fall below the 32-bit quotient window of |n| * 2^(FRAC_BITS-1)
  localparam int LOW_W = ROOT_W - (FRAC_BITS - 1);

  logic [NUM_W-1:0]  mag;
  logic              ovf_c;

  logic [ROOT_W-1:0] h_q   [DIV_STEPS+1];
  logic [ROOT_W-1:0] rem_q [DIV_STEPS+1];
  logic [ROOT_W-1:0] q_q   [DIV_STEPS+1];
  logic [LOW_W-1:0]  lo_q  [DIV_STEPS+1];
  logic              neg_q [DIV_STEPS+1];
  logic              ovf_q [DIV_STEPS+1];

  // quotient fits 32 bits exactly when |n| < 8h
  always_comb begin
    mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    ovf_c = {2'b00, mag} >= {h, 3'b000};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_q[0]   <= h;
      rem_q[0] <= ROOT_W'(mag[NUM_W-1:LOW_W]);
      q_q[0]   <= '0;
      lo_q[0]  <= mag[LOW_W-1:0];
      neg_q[0] <= num[NUM_W-1];
      ovf_q[0] <= ovf_c;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    localparam int K = DIV_STEPS - 1 - j;
    logic [ROOT_W-1:0] dl;
    logic [ROOT_W:0]   rem2, diff;
    logic              ge;

    always_comb begin
      dl   = {lo_q[j], {(ROOT_W-LOW_W){1'b0}}};
      rem2 = {rem_q[j], dl[K]};
      ge   = rem2 >= {1'b0, h_q[j]};
      diff = rem2 - {1'b0, h_q[j]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        h_q[j+1]   <= h_q[j];
        lo_q[j+1]  <= lo_q[j];
        neg_q[j+1] <= neg_q[j];
        ovf_q[j+1] <= ovf_q[j];
        q_q[j+1]   <= {q_q[j][ROOT_W-2:0], ge};
        rem_q[j+1] <= ge ? diff[ROOT_W-1:0] : rem2[ROOT_W-1:0];
      end
    end
  end

  assign quo = q_q[DIV_STEPS];
  assign neg = neg_q[DIV_STEPS];
  assign ovf = ovf_q[DIV_STEPS];

endmodule

>>> rtl/core/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix to quaternion (Shepperd), fully pipelined.
// Stages: input register, branch/radicand stage, 32 root stages,
// divide setup plus 32 quotient stages, and the output register.
// Throughput is one matrix per cycle; a stalled output freezes the whole pipeline.
// Reset clears the valid bits and sets trace_threshold to 11; datapath is not reset.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  matrix_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output quat_t       out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [THR_W-1:0]  thr;
  logic [NSTG-1:0]   v;
  logic              en;
  logic [RAD_W-1:0]  rad;
  side_t             side_f, side_s;
  logic [ROOT_W-1:0] h;
  logic [ROOT_W-1:0] qa, qb, qc;
  logic              nega, negb, negc, ovfa, ovfb, ovfc;
  tail_t             tail_q [DIV_STEPS+1];
  tail_t             tl;
  quat_t             res_next;
  logic signed [MAT_W-1:0] ra, rb, rc, hf;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == THR_IDX) ? {1'b0, thr} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (psel && penable && pwrite && paddr[2] == THR_IDX) begin
      thr <= pwdata[THR_W-1:0];
    end
  end

  assign en        = !(v[NSTG-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = v[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NSTG-2:0], in_valid};
    end
  end

  rmq_front u_front (
    .clk  (clk),
    .en   (en),
    .mat  (in_data),
    .thr  (thr),
    .rad  (rad),
    .side (side_f)
  );

  rmq_sqrt u_sqrt (
    .clk     (clk),
    .en      (en),
    .rad_in  (rad),
    .side_in (side_f),
    .root    (h),
    .side    (side_s)
  );

  rmq_div u_div_a (.clk(clk), .en(en), .num(side_s.na), .h(h), .quo(qa), .neg(nega), .ovf(ovfa));
  rmq_div u_div_b (.clk(clk), .en(en), .num(side_s.nb), .h(h), .quo(qb), .neg(negb), .ovf(ovfb));
  rmq_div u_div_c (.clk(clk), .en(en), .num(side_s.nc), .h(h), .quo(qc), .neg(negc), .ovf(ovfc));

  // branch, half the root and the zero-divisor flag ride alongside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      tail_q[0].br   <= side_s.br;
      tail_q[0].half <= h[ROOT_W-1:1];
      tail_q[0].inv  <= (h == '0);
      for (int i = 0; i < DIV_STEPS; i++) begin
        tail_q[i+1] <= tail_q[i];
      end
    end
  end
  assign tl = tail_q[DIV_STEPS];

  function automatic logic signed [MAT_W-1:0] fix_q(input logic [ROOT_W-1:0] q,
                                                     input logic neg, input logic ovf);
    logic signed [MAT_W-1:0] res;
    if (neg) begin
      if (ovf || q > 32'h8000_0000) res = 32'sh8000_0000;
      else res = MAT_W'(-q);
    end else begin
      if (ovf || q[ROOT_W-1]) res = 32'sh7fff_ffff;
      else res = q;
    end
    return res;
  endfunction

  always_comb begin
    ra = fix_q(qa, nega, ovfa);
    rb = fix_q(qb, negb, ovfb);
    rc = fix_q(qc, negc, ovfc);
    hf = {1'b0, tl.half};
    res_next.branch_taken = tl.br;
    res_next.invalid      = tl.inv;
    case (tl.br)
      BR_TRACE: begin
        res_next.q_w = hf; res_next.q_x = ra; res_next.q_y = rb; res_next.q_z = rc;
      end
      BR_X: begin
        res_next.q_w = ra; res_next.q_x = hf; res_next.q_y = rb; res_next.q_z = rc;
      end
      BR_Y: begin
        res_next.q_w = ra; res_next.q_x = rb; res_next.q_y = hf; res_next.q_z = rc;
      end
      default: begin
        res_next.q_w = ra; res_next.q_x = rb; res_next.q_y = rc; res_next.q_z = hf;
      end
    endcase
    if (tl.inv) begin
      res_next.q_w = '0;
      res_next.q_x = '0;
      res_next.q_y = '0;
      res_next.q_z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res_next;
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.invalid |->
      out_data.q_w == 0 && out_data.q_x == 0 && out_data.q_y == 0 && out_data.q_z == 0)
    else $error("invalid result with nonzero components");

  a_big_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.invalid |->
      (out_data.branch_taken == BR_TRACE && !out_data.q_w[MAT_W-1]) ||
      (out_data.branch_taken == BR_X && !out_data.q_x[MAT_W-1]) ||
      (out_data.branch_taken == BR_Y && !out_data.q_y[MAT_W-1]) ||
      (out_data.branch_taken == BR_Z && !out_data.q_z[MAT_W-1]))
    else $error("component from square root is negative");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    !out_stall && v[NSTG-2] |=> out_valid)
    else $error("transaction lost at output register");

endmodule
